[rtl/core/esbm_pkg.sv]
// Package for the epipolar SAD best-match block: payload structs, queue entry,
// shared constants. Used by every module under rtl/core.
`default_nettype none
package esbm_pkg;

    localparam int ESBM_COORD_W    = 12;
    localparam int ESBM_PIX_W      = 8;
    localparam int ESBM_COST_W     = 19;
    localparam int ESBM_ADD_W      = 10;
    localparam int ESBM_DISP_W     = 12;
    localparam int ESBM_QUEUE_DEPTH = 4;
    localparam int ESBM_CHAN_MAX   = 765;
    localparam int ESBM_COST_MAX   = 524287;
    localparam int ESBM_DEF_RADIUS = 11;
    localparam int ESBM_DEF_COORD_BITS = 12;
    localparam logic [ESBM_DISP_W-1:0] ESBM_DISP_RESET = 12'd100;

    typedef struct packed {
        logic [ESBM_PIX_W-1:0]   left_blue;
        logic [ESBM_PIX_W-1:0]   left_green;
        logic [ESBM_PIX_W-1:0]   left_red;
        logic [ESBM_PIX_W-1:0]   right_blue;
        logic [ESBM_PIX_W-1:0]   right_green;
        logic [ESBM_PIX_W-1:0]   right_red;
        logic [ESBM_COORD_W-1:0] cand_x;
        logic [ESBM_COORD_W-1:0] cand_y;
        logic [ESBM_COORD_W-1:0] ref_x;
        logic [ESBM_COORD_W-1:0] ref_y;
        logic                    window_end;
        logic                    line_end;
    } t_esbm_in;

    typedef struct packed {
        logic [ESBM_COST_W-1:0]  window_cost;
        logic                    window_kept;
        logic                    line_done;
        logic [ESBM_COORD_W-1:0] best_x;
        logic [ESBM_COORD_W-1:0] best_y;
        logic [ESBM_COST_W-1:0]  best_cost;
        logic                    match_found;
    } t_esbm_out;

    typedef struct packed {
        logic [ESBM_ADD_W-1:0]   add;
        logic                    close;
        logic                    line_end;
        logic                    kept;
        logic [ESBM_COORD_W-1:0] cand_x;
        logic [ESBM_COORD_W-1:0] cand_y;
        logic [ESBM_COORD_W-1:0] ref_x;
        logic [ESBM_COORD_W-1:0] ref_y;
    } t_esbm_work;

    typedef struct packed {
        logic       valid;
        t_esbm_work work;
    } t_esbm_slot;

endpackage
`default_nettype wire

[rtl/core/epipolar_sad_best_match.sv]
// Top level of the epipolar SAD best-match block: configuration register,
// front end, work queue and back end. Uses esbm_pkg and the esbm_* modules.
//
// Takes one pixel pair per cycle on the input channel when not stalled, a
// rate set by the combinational saturating accumulate and best-cost compare
// in the back end, and returns one result per closed candidate window
// (window_end or line_end set) via the queue and the result register. A
// four-entry queue between front and back absorbs output stalls.
// max_disparity is written through the configuration channel, which
// is always ready, and must only be changed while the block is idle.
`default_nettype none
module epipolar_sad_best_match #(
    parameter int WINDOW_RADIUS = esbm_pkg::ESBM_DEF_RADIUS,
    parameter int COORD_BITS    = esbm_pkg::ESBM_DEF_COORD_BITS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [esbm_pkg::ESBM_DISP_W-1:0] i_cfg_data,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire esbm_pkg::t_esbm_in               i_in_data,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output esbm_pkg::t_esbm_out                   o_out_data
);
    import esbm_pkg::*;

    logic [ESBM_DISP_W-1:0] r_max_disparity;
    t_esbm_slot             push, head;
    logic                   queue_full, pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_disparity <= ESBM_DISP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_disparity <= i_cfg_data;
        end
    end

    esbm_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_in_data       (i_in_data),
        .i_max_disparity (r_max_disparity),
        .i_queue_full    (queue_full),
        .o_push          (push)
    );

    esbm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_head  (head)
    );

    esbm_back #(
        .WINDOW_RADIUS (WINDOW_RADIUS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

[rtl/core/esbm_front.sv]
// Front end: accepts pixel pairs, forms the per-pair channel SAD and the
// disparity decision, and pushes work entries into the queue. Uses esbm_pkg.
`default_nettype none
module esbm_front #(
    parameter int COORD_BITS = esbm_pkg::ESBM_DEF_COORD_BITS
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire esbm_pkg::t_esbm_in                   i_in_data,
    input  wire logic [esbm_pkg::ESBM_DISP_W-1:0]     i_max_disparity,
    input  wire logic                                 i_queue_full,
    output esbm_pkg::t_esbm_slot                      o_push
);
    import esbm_pkg::*;

    localparam logic [ESBM_COORD_W-1:0] CoordMask = (COORD_BITS >= ESBM_COORD_W) ?
        {ESBM_COORD_W{1'b1}} : ESBM_COORD_W'((1 << COORD_BITS) - 1);

    function automatic logic [ESBM_PIX_W-1:0] abs_diff(
        input logic [ESBM_PIX_W-1:0] a,
        input logic [ESBM_PIX_W-1:0] b
    );
        abs_diff = (a > b) ? a - b : b - a;
    endfunction

    logic [ESBM_COORD_W-1:0] cx, cy, rx, ry, disp;
    logic [ESBM_ADD_W-1:0]   add;

    always_comb begin
        cx   = i_in_data.cand_x & CoordMask;
        cy   = i_in_data.cand_y & CoordMask;
        rx   = i_in_data.ref_x & CoordMask;
        ry   = i_in_data.ref_y & CoordMask;
        disp = (cx > rx) ? cx - rx : rx - cx;
        add  = ESBM_ADD_W'(abs_diff(i_in_data.left_blue, i_in_data.right_blue))
             + ESBM_ADD_W'(abs_diff(i_in_data.left_green, i_in_data.right_green))
             + ESBM_ADD_W'(abs_diff(i_in_data.left_red, i_in_data.right_red));
    end

    assign o_in_stall = i_queue_full || !i_rst_n;

    always_comb begin
        o_push.valid         = i_in_valid && !i_queue_full && i_rst_n;
        o_push.work.add      = add;
        o_push.work.close    = i_in_data.window_end || i_in_data.line_end;
        o_push.work.line_end = i_in_data.line_end;
        o_push.work.kept     = (disp <= i_max_disparity);
        o_push.work.cand_x   = cx;
        o_push.work.cand_y   = cy;
        o_push.work.ref_x    = rx;
        o_push.work.ref_y    = ry;
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_queue_full |-> !o_push.valid)
        else $error("push into full queue");
    a_stall_follows_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall == i_queue_full)
        else $error("stall out of step with queue");
    a_close_on_line_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.valid && o_push.work.line_end) |-> o_push.work.close)
        else $error("line end entry not closing");
`endif

endmodule
`default_nettype wire

[rtl/core/esbm_queue.sv]
// Short queue of work entries between front end and back end.
// Register-based ring of esbm_pkg::ESBM_QUEUE_DEPTH entries. Uses esbm_pkg.
`default_nettype none
module esbm_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire esbm_pkg::t_esbm_slot i_push,
    input  wire logic                 i_pop,
    output logic                      o_full,
    output esbm_pkg::t_esbm_slot      o_head
);
    import esbm_pkg::*;

    localparam int PtrW = $clog2(ESBM_QUEUE_DEPTH);
    localparam int CntW = $clog2(ESBM_QUEUE_DEPTH + 1);

    t_esbm_work            r_mem [ESBM_QUEUE_DEPTH];
    logic [PtrW-1:0]       r_wr_ptr, r_rd_ptr;
    logic [CntW-1:0]       r_count, n_count;

    always_comb begin
        n_count = r_count;
        if (i_push.valid && !i_pop) begin
            n_count = r_count + CntW'(1);
        end else if (!i_push.valid && i_pop) begin
            n_count = r_count - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= r_wr_ptr + PtrW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PtrW'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.work;
        end
    end

    assign o_full       = (r_count == CntW'(ESBM_QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.work  = r_mem[r_rd_ptr];

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(ESBM_QUEUE_DEPTH))
        else $error("queue count overflow");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head.valid)
        else $error("pop from empty queue");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        PtrW'(r_wr_ptr - r_rd_ptr) == PtrW'(r_count))
        else $error("queue pointers disagree with count");
`endif

endmodule
`default_nettype wire

[rtl/core/esbm_back.sv]
// Back end: saturating window accumulator, best-candidate tracking and the
// result register. Consumes queue entries. Uses esbm_pkg.
`default_nettype none
module esbm_back #(
    parameter int WINDOW_RADIUS = esbm_pkg::ESBM_DEF_RADIUS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire esbm_pkg::t_esbm_slot i_head,
    output logic                      o_pop,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output esbm_pkg::t_esbm_out       o_out_data
);
    import esbm_pkg::*;

    localparam longint WinSide  = 2 * WINDOW_RADIUS + 1;
    localparam longint WinFull  = WinSide * WinSide * ESBM_CHAN_MAX;
    localparam logic [ESBM_COST_W-1:0] CostLimit = (WinFull > ESBM_COST_MAX) ?
        {ESBM_COST_W{1'b1}} : ESBM_COST_W'(WinFull);

    logic [ESBM_COST_W-1:0]  r_window_sum, n_window_sum;
    logic [ESBM_COST_W-1:0]  r_lowest_cost, n_lowest_cost;
    logic [ESBM_COORD_W-1:0] r_lowest_x, n_lowest_x;
    logic [ESBM_COORD_W-1:0] r_lowest_y, n_lowest_y;
    logic                    r_any_kept, n_any_kept;
    logic                    r_out_valid, n_out_valid;
    t_esbm_out               r_out_data, n_out_data;

    logic [ESBM_COST_W:0]    sum_wide;
    logic [ESBM_COST_W-1:0]  sum_sat, cost;
    logic                    out_free, take_best;
    t_esbm_work              w;

    always_comb begin
        w        = i_head.work;
        out_free = !r_out_valid || !i_out_stall;
        o_pop    = i_head.valid && (!w.close || out_free);

        sum_wide = {1'b0, r_window_sum} + (ESBM_COST_W + 1)'(w.add);
        sum_sat  = (sum_wide > (ESBM_COST_W + 1)'(CostLimit)) ?
                   CostLimit : sum_wide[ESBM_COST_W-1:0];
        cost      = w.kept ? sum_sat : '0;
        take_best = w.kept && (!r_any_kept || cost < r_lowest_cost);

        n_window_sum  = r_window_sum;
        n_lowest_cost = r_lowest_cost;
        n_lowest_x    = r_lowest_x;
        n_lowest_y    = r_lowest_y;
        n_any_kept    = r_any_kept;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_data    = r_out_data;

        if (o_pop) begin
            if (!w.close) begin
                n_window_sum = sum_sat;
            end else begin
                n_window_sum = '0;
                if (take_best) begin
                    n_lowest_cost = cost;
                    n_lowest_x    = w.cand_x;
                    n_lowest_y    = w.cand_y;
                    n_any_kept    = 1'b1;
                end
                n_out_valid            = 1'b1;
                n_out_data.window_cost = cost;
                n_out_data.window_kept = w.kept;
                n_out_data.line_done   = w.line_end;
                n_out_data.best_x      = n_any_kept ? n_lowest_x : w.ref_x;
                n_out_data.best_y      = n_any_kept ? n_lowest_y : w.ref_y;
                n_out_data.best_cost   = n_any_kept ? n_lowest_cost : '0;
                n_out_data.match_found = n_any_kept;
                if (w.line_end) begin
                    n_lowest_cost = '0;
                    n_lowest_x    = '0;
                    n_lowest_y    = '0;
                    n_any_kept    = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_sum  <= '0;
            r_lowest_cost <= '0;
            r_lowest_x    <= '0;
            r_lowest_y    <= '0;
            r_any_kept    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_window_sum  <= n_window_sum;
            r_lowest_cost <= n_lowest_cost;
            r_lowest_x    <= n_lowest_x;
            r_lowest_y    <= n_lowest_y;
            r_any_kept    <= n_any_kept;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTHESIS
    a_sum_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_window_sum <= CostLimit)
        else $error("window sum above limit");
    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_data.window_kept) |-> (r_out_data.window_cost == '0))
        else $error("skipped window with nonzero cost");
    a_no_match_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_data.match_found) |-> (r_out_data.best_cost == '0))
        else $error("best cost without match");
    a_line_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && w.close && w.line_end) |=> (!r_any_kept && r_window_sum == '0))
        else $error("line end did not clear state");
`endif

endmodule
`default_nettype wire

[sim/epipolar_sad_best_match_tb.sv]
`timescale 1ns / 1ps
// Testbench for epipolar_sad_best_match: directed, hold-off, saturation, limit and random
// line tests, each result checked against a SAD best-match predictor kept in this file.
// Depends on esbm_pkg and the block under rtl/core.
module epipolar_sad_best_match_tb;
    import esbm_pkg::*;

    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int DRAIN_TAIL       = 8;
    localparam int MAX_REPORTS      = 10;
    localparam int RANDOM_PER_PHASE = 140;
    localparam int WIN_SIDE         = 2 * ESBM_DEF_RADIUS + 1;
    localparam int FULL_WIN_COST    = WIN_SIDE * WIN_SIDE * ESBM_CHAN_MAX;
    localparam int COST_CAP = (FULL_WIN_COST > ESBM_COST_MAX) ? ESBM_COST_MAX : FULL_WIN_COST;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [ESBM_DISP_W-1:0] cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    t_esbm_in               in_data   = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    t_esbm_out              out_data;

    // predictor state
    int unsigned             acc_sum    = 0;
    logic [ESBM_COST_W-1:0]  low_cost   = '0;
    logic [ESBM_COORD_W-1:0] low_x      = '0;
    logic [ESBM_COORD_W-1:0] low_y      = '0;
    bit                      have_match = 1'b0;
    logic [ESBM_DISP_W-1:0]  disp_limit = ESBM_DISP_RESET;

    t_esbm_out pending_matches[$];
    int        errors      = 0;
    int        idle_cycles = 0;
    int        items_sent  = 0;
    bit        idle_on     = 1'b1;
    int        stall_left  = 0;
    int        free_left   = 0;

    epipolar_sad_best_match u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    initial forever #1 clk = ~clk;

    function automatic int unsigned abs_diff(input logic [7:0] a, input logic [7:0] b);
        int unsigned x;
        int unsigned y;
        x = 32'(a);
        y = 32'(b);
        return (x > y) ? x - y : y - x;
    endfunction

    function automatic bit sad_predict(input t_esbm_in px, output t_esbm_out res);
        int unsigned sum;
        int unsigned col_gap;
        int unsigned cost;
        bit          kept;
        res = '0;
        sum = acc_sum + abs_diff(px.left_blue, px.right_blue)
            + abs_diff(px.left_green, px.right_green) + abs_diff(px.left_red, px.right_red);
        if (sum > COST_CAP) sum = COST_CAP;
        acc_sum = sum;
        if (!px.window_end && !px.line_end) return 1'b0;
        col_gap = (px.cand_x > px.ref_x) ? 32'(px.cand_x - px.ref_x)
                                         : 32'(px.ref_x - px.cand_x);
        kept = (col_gap <= 32'(disp_limit));
        cost = kept ? acc_sum : 0;
        if (kept && (!have_match || cost < 32'(low_cost))) begin
            low_cost   = cost[ESBM_COST_W-1:0];
            low_x      = px.cand_x;
            low_y      = px.cand_y;
            have_match = 1'b1;
        end
        acc_sum = 0;
        res.window_cost = cost[ESBM_COST_W-1:0];
        res.window_kept = kept;
        res.line_done   = px.line_end;
        res.best_x      = have_match ? low_x : px.ref_x;
        res.best_y      = have_match ? low_y : px.ref_y;
        res.best_cost   = have_match ? low_cost : '0;
        res.match_found = have_match;
        if (px.line_end) begin
            low_cost   = '0;
            low_x      = '0;
            low_y      = '0;
            have_match = 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic int idle_length();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_esbm_in make_px(input logic [7:0] lb, input logic [7:0] lg,
                                         input logic [7:0] lr, input logic [7:0] rb,
                                         input logic [7:0] rg, input logic [7:0] rr,
                                         input logic [11:0] cx, input logic [11:0] cy,
                                         input logic [11:0] rx, input logic [11:0] ry,
                                         input logic we, input logic le);
        t_esbm_in px;
        px.left_blue   = lb;
        px.left_green  = lg;
        px.left_red    = lr;
        px.right_blue  = rb;
        px.right_green = rg;
        px.right_red   = rr;
        px.cand_x      = cx;
        px.cand_y      = cy;
        px.ref_x       = rx;
        px.ref_y       = ry;
        px.window_end  = we;
        px.line_end    = le;
        return px;
    endfunction

    function automatic logic [11:0] pick_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return 12'($urandom_range(0, 4095));
    endfunction

    function automatic logic [11:0] pick_cand(input logic [11:0] rx);
        int r;
        int off;
        int cx;
        r = $urandom_range(0, 9);
        if (r >= 8) return 12'($urandom_range(0, 4095));
        if (r < 4) off = int'(disp_limit) + int'($urandom_range(0, 2)) - 1;
        else off = int'($urandom_range(0, 32'(disp_limit)));
        if ($urandom_range(0, 1)) off = -off;
        cx = int'(rx) + off;
        if (cx < 0) cx = 0;
        if (cx > 4095) cx = 4095;
        return cx[11:0];
    endfunction

    function automatic t_esbm_in random_pixels(input int mode);
        t_esbm_in px;
        px = '0;
        px.left_blue  = 8'($urandom_range(0, 255));
        px.left_green = 8'($urandom_range(0, 255));
        px.left_red   = 8'($urandom_range(0, 255));
        case (mode)
            0: begin
                px.right_blue  = 8'($urandom_range(0, 255));
                px.right_green = 8'($urandom_range(0, 255));
                px.right_red   = 8'($urandom_range(0, 255));
            end
            1: begin
                px.right_blue  = px.left_blue ^ 8'($urandom_range(0, 1));
                px.right_green = px.left_green ^ 8'($urandom_range(0, 1));
                px.right_red   = px.left_red ^ 8'($urandom_range(0, 1));
            end
            2: begin
                px.left_blue   = {8{1'($urandom_range(0, 1))}};
                px.left_green  = {8{1'($urandom_range(0, 1))}};
                px.left_red    = {8{1'($urandom_range(0, 1))}};
                px.right_blue  = {8{1'($urandom_range(0, 1))}};
                px.right_green = {8{1'($urandom_range(0, 1))}};
                px.right_red   = {8{1'($urandom_range(0, 1))}};
            end
            default: begin
                px.right_blue  = px.left_blue;
                px.right_green = px.left_green;
                px.right_red   = px.left_red;
            end
        endcase
        return px;
    endfunction

    function automatic t_esbm_in noise_pixel();
        t_esbm_in px;
        px = random_pixels(0);
        px.cand_x     = 12'($urandom_range(0, 4095));
        px.cand_y     = 12'($urandom_range(0, 4095));
        px.ref_x      = 12'($urandom_range(0, 4095));
        px.ref_y      = 12'($urandom_range(0, 4095));
        px.window_end = 1'($urandom_range(0, 1));
        px.line_end   = 1'($urandom_range(0, 1));
        return px;
    endfunction

    task automatic send_pixel(input t_esbm_in px);
        int        gap;
        t_esbm_out res;
        gap = idle_length();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= px;
        do @(posedge clk); while (in_stall);
        if (sad_predict(px, res)) pending_matches = {pending_matches, res};
        items_sent++;
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_matches.size() != 0);
    endtask

    task automatic drain();
        hold_until_drained();
        repeat (DRAIN_TAIL) @(posedge clk);
    endtask

    task automatic write_disp_limit(input logic [ESBM_DISP_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        disp_limit = value;
    endtask

    task automatic send_random_line();
        int          n_win;
        int          len;
        int          mode;
        bit          last;
        bit          last_win;
        logic [11:0] rx;
        logic [11:0] ry;
        logic [11:0] cx;
        logic [11:0] cy;
        t_esbm_in    px;
        rx    = pick_coord();
        ry    = pick_coord();
        n_win = $urandom_range(1, 8);
        for (int w = 0; w < n_win; w++) begin
            len      = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 40)
                                                     : $urandom_range(1, 6);
            mode     = $urandom_range(0, 3);
            cx       = pick_cand(rx);
            cy       = pick_coord();
            last_win = (w == n_win - 1);
            for (int i = 0; i < len; i++) begin
                last = (i == len - 1);
                px   = random_pixels(mode);
                if (last) begin
                    px.cand_x = cx;
                    px.cand_y = cy;
                    px.ref_x  = rx;
                    px.ref_y  = ry;
                end else begin
                    px.cand_x = 12'($urandom_range(0, 4095));
                    px.cand_y = 12'($urandom_range(0, 4095));
                    px.ref_x  = $urandom_range(0, 1) ? rx : 12'($urandom_range(0, 4095));
                    px.ref_y  = 12'($urandom_range(0, 4095));
                end
                px.window_end = last && !(last_win && $urandom_range(0, 1));
                px.line_end   = last && last_win;
                if (i > 0 && $urandom_range(0, 299) == 0) hold_until_drained();
                send_pixel(px);
            end
        end
    endtask

    task automatic test_directed();
        // window kept at the limit on both sides, skipped one past it, ties keep the first
        send_pixel(make_px(255, 255, 255, 0, 0, 0, 2000, 10, 2000, 500, 1, 0));
        send_pixel(make_px(0, 0, 0, 255, 255, 255, 1, 2, 3, 4, 0, 0));
        send_pixel(make_px(10, 20, 30, 5, 25, 30, 2100, 11, 2000, 500, 1, 0));
        send_pixel(make_px(7, 7, 7, 7, 7, 7, 2101, 12, 2000, 500, 1, 0));
        send_pixel(make_px(1, 2, 3, 0, 2, 4, 1900, 13, 2000, 500, 1, 0));
        send_pixel(make_px(0, 0, 0, 0, 0, 0, 1899, 14, 2000, 500, 1, 0));
        send_pixel(make_px(0, 0, 2, 0, 0, 0, 1950, 15, 2000, 500, 1, 0));
        // line end alone closes the window
        send_pixel(make_px(128, 128, 128, 128, 128, 128, 2000, 4095, 2000, 500, 0, 1));
        // nothing kept: report the reference point; then a lone window kept at the limit
        send_pixel(make_px(0, 255, 0, 255, 0, 255, 0, 0, 4095, 4095, 1, 0));
        send_pixel(make_px(255, 0, 255, 0, 255, 0, 3994, 4095, 4095, 4095, 1, 1));
        send_pixel(make_px(255, 255, 255, 255, 255, 255, 100, 4095, 0, 0, 0, 1));
        // coordinates come from the closing pair only
        send_pixel(make_px(50, 60, 70, 80, 90, 100, 4000, 4000, 4095, 4095, 0, 0));
        send_pixel(make_px(200, 100, 0, 0, 100, 200, 50, 4095, 0, 0, 1, 1));
        send_pixel(make_px(0, 0, 0, 0, 0, 0, 4095, 0, 4095, 4095, 0, 0));
        send_pixel(make_px(0, 0, 0, 0, 0, 0, 4095, 0, 4095, 4095, 1, 1));
    endtask

    task automatic test_hold_off();
        for (int i = 0; i < 3; i++) send_pixel(make_px(9, 8, 7, 1, 2, 3, 300, 300, 310, 20, 0, 0));
        hold_until_drained();
        send_pixel(make_px(9, 8, 7, 1, 2, 3, 300, 301, 310, 20, 1, 0));
        send_pixel(make_px(4, 4, 4, 4, 4, 5, 320, 302, 310, 20, 0, 0));
        hold_until_drained();
        send_pixel(make_px(4, 4, 4, 4, 4, 5, 320, 303, 310, 20, 1, 1));
    endtask

    task automatic test_window_saturation();
        for (int i = 0; i < 700; i++)
            send_pixel(make_px(255, 0, 255, 0, 255, 0, 77, 88, 77, 99, 0, i == 699));
        for (int i = 0; i < 529; i++)
            send_pixel(make_px(0, 0, 0, 255, 255, 255, 60, 61, 77, 99, i == 528, 1'b0));
        send_pixel(make_px(3, 0, 0, 0, 0, 0, 61, 62, 77, 99, 1, 1));
    endtask

    task automatic test_limit_extremes();
        drain();
        write_disp_limit('0);
        send_pixel(make_px(1, 1, 1, 2, 2, 2, 1234, 5, 1234, 6, 1, 0));
        send_pixel(make_px(0, 0, 0, 0, 0, 0, 1235, 5, 1234, 6, 1, 0));
        send_pixel(make_px(0, 0, 0, 0, 0, 0, 1233, 5, 1234, 6, 1, 1));
        drain();
        write_disp_limit('1);
        send_pixel(make_px(10, 10, 10, 0, 0, 0, 0, 1, 4095, 2, 1, 0));
        send_pixel(make_px(0, 0, 0, 1, 1, 1, 4095, 3, 0, 2, 1, 1));
        for (int i = 0; i < 12; i++) send_pixel(noise_pixel());
    endtask

    task automatic test_random_lines();
        logic [ESBM_DISP_W-1:0] limits[4];
        limits[0] = ESBM_DISP_RESET;
        limits[1] = 12'($urandom_range(0, 4095));
        limits[2] = 12'($urandom_range(0, 15));
        limits[3] = 12'($urandom_range(2000, 4095));
        for (int p = 0; p < 4; p++) begin
            drain();
            write_disp_limit(limits[p]);
            idle_on    = (p != 1);
            items_sent = 0;
            while (items_sent < RANDOM_PER_PHASE) begin
                if ($urandom_range(0, 9) == 0) send_pixel(noise_pixel());
                else send_random_line();
            end
        end
        idle_on = 1'b1;
    endtask

    task automatic flag_result(input string why, input t_esbm_out want, input t_esbm_out got);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("%s: expected cost=%0d kept=%0b done=%0b best=(%0d,%0d) cost=%0d found=%0b",
                     why, want.window_cost, want.window_kept, want.line_done,
                     want.best_x, want.best_y, want.best_cost, want.match_found);
            $display("    got      cost=%0d kept=%0b done=%0b best=(%0d,%0d) cost=%0d found=%0b",
                     got.window_cost, got.window_kept, got.line_done,
                     got.best_x, got.best_y, got.best_cost, got.match_found);
        end
    endtask

    always @(posedge clk) begin : check_results
        t_esbm_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_matches.size() == 0) begin
                flag_result("unexpected result", '0, out_data);
            end else begin
                want = pending_matches.pop_front();
                if (out_data.window_cost !== want.window_cost ||
                    out_data.window_kept !== want.window_kept ||
                    out_data.line_done   !== want.line_done   ||
                    out_data.best_x      !== want.best_x      ||
                    out_data.best_y      !== want.best_y      ||
                    out_data.best_cost   !== want.best_cost   ||
                    out_data.match_found !== want.match_found)
                    flag_result("result mismatch", want, out_data);
            end
        end
        if (!idle_on) begin
            out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else if (free_left > 0) begin
            out_stall <= 1'b0;
            free_left--;
        end else begin
            out_stall  <= 1'b0;
            stall_left = idle_length();
            free_left  = $urandom_range(0, 10);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_hold_off();
        test_window_saturation();
        test_limit_extremes();
        test_random_lines();
        drain();
        errors += pending_matches.size();
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
